>>> rtl/core/node_pool_with_depth_lists_top_defines.svh
// Assertion macros used by the node pool top level.
`ifndef NODE_POOL_WITH_DEPTH_LISTS_TOP_DEFINES_SVH
`define NODE_POOL_WITH_DEPTH_LISTS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define NPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("node pool same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define NPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("node pool next-cycle check failed");
`else
`define NPD_ASSERT_NOW(label, ante, cons)
`define NPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/npd_pkg.sv
// Package with shared constants, codes and handshake types of the node pool.
package npd_pkg;

    // Default pool geometry.
    localparam int NPD_POOL_SLOTS = 256;
    localparam int NPD_LEVELS     = 10;

    // Request codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DEPTH = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic link;
    } npd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_link;
    } npd_sts_t;

endpackage

>>> rtl/core/node_pool_with_depth_lists_top.sv
// Top level of the node pool with one doubly linked list per depth.
// A result is registered in execute after its item is captured; a stalled result
// holds the next item in execute until the result is taken.
// An item runs capture, execute and, for an allocate that appends to a non-empty list,
// link, set by the single next-link write port; no new item is taken until it is done.
// Reset: asynchronous, active low; all lists empty and the free stack ready at once,
// no clearing pass (a watermark stands for the free links never written).
module node_pool_with_depth_lists_top #(
    parameter int POOL_SLOTS = npd_pkg::NPD_POOL_SLOTS,
    parameter int LEVELS     = npd_pkg::NPD_LEVELS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic       parent_is_root,
    input  logic [7:0] parent_slot,
    input  logic [7:0] release_slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] slot_index,
    output logic [3:0] node_level,
    output logic [1:0] status
);
    import npd_pkg::*;

    `include "node_pool_with_depth_lists_top_defines.svh"

    npd_cmd_t cmd;
    npd_sts_t sts;

    // Sequencer.
    npd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Pool storage and result register.
    npd_dp #(
        .POOL_SLOTS (POOL_SLOTS),
        .LEVELS     (LEVELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .parent_is_root (parent_is_root),
        .parent_slot    (parent_slot),
        .release_slot   (release_slot),
        .slot_index     (slot_index),
        .node_level     (node_level),
        .status         (status)
    );

    // Commands never overlap, and each item runs capture, execute, then maybe link.
    `NPD_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.exec, cmd.link}))
    `NPD_ASSERT_NEXT(a_load_then_exec, cmd.load, !in_stall == 1'b0)
    `NPD_ASSERT_NOW(a_link_after_exec, cmd.link, $past(cmd.exec))
    `NPD_ASSERT_NOW(a_busy_no_accept, cmd.exec || cmd.link, in_stall)

endmodule

>>> rtl/core/npd_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module npd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output npd_pkg::npd_cmd_t cmd,
    input  npd_pkg::npd_sts_t sts
);
    import npd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       go;

    // The result slot is free when empty or being taken this cycle.
    assign go = !out_valid_reg || !out_stall;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = go;
                if (go)
                begin
                    state_next = sts.need_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid is set when a result is loaded and cleared when it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/npd_dp.sv
// Datapath with the free stack, the per-depth link memories and the result register.
module npd_dp #(
    parameter int POOL_SLOTS = npd_pkg::NPD_POOL_SLOTS,
    parameter int LEVELS     = npd_pkg::NPD_LEVELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  npd_pkg::npd_cmd_t cmd,
    output npd_pkg::npd_sts_t sts,
    input  logic              opcode,
    input  logic              parent_is_root,
    input  logic [7:0]        parent_slot,
    input  logic [7:0]        release_slot,
    output logic [7:0]        slot_index,
    output logic [3:0]        node_level,
    output logic [1:0]        status
);
    import npd_pkg::*;

    localparam int IW  = $clog2(POOL_SLOTS);
    localparam int LW  = $clog2(POOL_SLOTS + 1);
    localparam int LVW = $clog2(LEVELS);
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    // Memories.
    logic [LW-1:0] free_mem  [POOL_SLOTS];
    logic [LW-1:0] prev_mem  [POOL_SLOTS];
    logic [LW-1:0] next_mem  [POOL_SLOTS];
    logic [3:0]    level_mem [POOL_SLOTS];

    // List ends and free stack control.
    logic [LW-1:0] first_reg [LEVELS];
    logic [LW-1:0] last_reg  [LEVELS];
    logic [LW-1:0] free_top_reg;
    logic [LW-1:0] free_top_next;
    logic [LW-1:0] water_reg;
    logic [LW-1:0] water_next;

    // Captured request and read data.
    logic          op_reg;
    logic          root_reg;
    logic [7:0]    parent_reg;
    logic [7:0]    rel_reg;
    logic [LW-1:0] fl_rd_reg;
    logic [LW-1:0] prev_rd_reg;
    logic [LW-1:0] next_rd_reg;
    logic [3:0]    lvl_rd_reg;
    logic [LW-1:0] tail_reg;
    logic [LW-1:0] link_slot_reg;

    // Result register.
    logic [7:0] slot_index_reg;
    logic [7:0] slot_index_next;
    logic [3:0] node_level_reg;
    logic [3:0] node_level_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    // Address forms of the request fields.
    logic [15:0]   in_par_wide;
    logic [15:0]   in_rel_wide;
    logic [15:0]   par_wide;
    logic [15:0]   rel_wide;
    logic [15:0]   top_wide;
    logic [IW-1:0] rd_lvl_addr;

    // Execute-cycle decode.
    logic          is_alloc;
    logic          empty;
    logic          parent_in;
    logic [4:0]    depth;
    logic          depth_over;
    logic          alloc_ok;
    logic [LVW-1:0] didx;
    logic [LW-1:0] tail;
    logic          tail_in;
    logic [LW-1:0] fl_val;
    logic          rel_ok;
    logic          lvl_in;
    logic [LVW-1:0] lidx;
    logic          p_in;
    logic          n_in;

    // Memory write ports.
    logic          prev_we;
    logic [IW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;
    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [LW-1:0] next_wd;

    assign in_par_wide = 16'(parent_slot);
    assign in_rel_wide = 16'(release_slot);
    assign par_wide    = 16'(parent_reg);
    assign rel_wide    = 16'(rel_reg);
    assign top_wide    = 16'(free_top_reg);
    assign rd_lvl_addr = (opcode == OP_RELEASE) ? in_rel_wide[IW-1:0] : in_par_wide[IW-1:0];

    // Decode of the captured request against the read data.
    always_comb
    begin
        is_alloc   = (op_reg == OP_ALLOC);
        empty      = (free_top_reg >= NIL);
        parent_in  = (par_wide < 16'(POOL_SLOTS));
        depth      = (root_reg || !parent_in) ? 5'd1 : (5'(lvl_rd_reg) + 5'd1);
        depth_over = (depth >= 5'(LEVELS));
        alloc_ok   = is_alloc && !empty && !depth_over;
        didx       = depth[LVW-1:0];
        tail       = last_reg[didx];
        tail_in    = (tail < NIL);
        fl_val     = (free_top_reg < water_reg) ? fl_rd_reg : (free_top_reg + LW'(1));
        rel_ok     = !is_alloc && (rel_wide < 16'(POOL_SLOTS));
        lvl_in     = (5'(lvl_rd_reg) < 5'(LEVELS));
        lidx       = lvl_rd_reg[LVW-1:0];
        p_in       = (prev_rd_reg < NIL);
        n_in       = (next_rd_reg < NIL);
    end

    assign sts.need_link = alloc_ok && tail_in;

    // Result values.
    always_comb
    begin
        if (is_alloc)
        begin
            if (empty)
            begin
                slot_index_next = 8'd0;
                node_level_next = 4'd0;
                status_next     = ST_EMPTY;
            end
            else if (depth_over)
            begin
                slot_index_next = 8'd0;
                node_level_next = (depth > 5'd15) ? 4'd15 : depth[3:0];
                status_next     = ST_DEPTH;
            end
            else
            begin
                slot_index_next = top_wide[7:0];
                node_level_next = depth[3:0];
                status_next     = ST_OK;
            end
        end
        else
        begin
            slot_index_next = rel_reg;
            node_level_next = rel_ok ? lvl_rd_reg : 4'd0;
            status_next     = ST_OK;
        end
    end

    // Free stack head and the watermark of slots whose free link was never written.
    always_comb
    begin
        free_top_next = free_top_reg;
        water_next    = water_reg;
        if (cmd.exec && alloc_ok)
        begin
            free_top_next = fl_val;
            if (free_top_reg >= water_reg)
            begin
                water_next = free_top_reg + LW'(1);
            end
        end
        else if (cmd.exec && rel_ok)
        begin
            free_top_next = rel_wide[LW-1:0];
        end
    end

    // Previous-link and next-link write ports.
    always_comb
    begin
        prev_we = 1'b0;
        prev_wa = free_top_reg[IW-1:0];
        prev_wd = tail;
        next_we = 1'b0;
        next_wa = free_top_reg[IW-1:0];
        next_wd = NIL;
        if (cmd.exec && alloc_ok)
        begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end
        else if (cmd.exec && rel_ok)
        begin
            prev_we = n_in;
            prev_wa = next_rd_reg[IW-1:0];
            prev_wd = prev_rd_reg;
            next_we = p_in;
            next_wa = prev_rd_reg[IW-1:0];
            next_wd = next_rd_reg;
        end
        else if (cmd.link)
        begin
            next_we = 1'b1;
            next_wa = tail_reg[IW-1:0];
            next_wd = link_slot_reg;
        end
    end

    // Free-link memory.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && rel_ok)
        begin
            free_mem[rel_wide[IW-1:0]] <= free_top_reg;
        end
        if (cmd.load)
        begin
            fl_rd_reg <= free_mem[free_top_reg[IW-1:0]];
        end
    end

    // Previous-link memory.
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.load)
        begin
            prev_rd_reg <= prev_mem[in_rel_wide[IW-1:0]];
        end
    end

    // Next-link memory.
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (cmd.load)
        begin
            next_rd_reg <= next_mem[in_rel_wide[IW-1:0]];
        end
    end

    // Slot depth memory.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && alloc_ok)
        begin
            level_mem[free_top_reg[IW-1:0]] <= depth[3:0];
        end
        if (cmd.load)
        begin
            lvl_rd_reg <= level_mem[rd_lvl_addr];
        end
    end

    // Request capture, link hand-over and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            root_reg   <= parent_is_root;
            parent_reg <= parent_slot;
            rel_reg    <= release_slot;
        end
        if (cmd.exec)
        begin
            tail_reg       <= tail;
            link_slot_reg  <= free_top_reg;
            slot_index_reg <= slot_index_next;
            node_level_reg <= node_level_next;
            status_reg     <= status_next;
        end
    end

    // List ends and free stack registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                first_reg[i] <= NIL;
                last_reg[i]  <= NIL;
            end
            free_top_reg <= '0;
            water_reg    <= '0;
        end
        else
        begin
            free_top_reg <= free_top_next;
            water_reg    <= water_next;
            if (cmd.exec && alloc_ok)
            begin
                if (!tail_in)
                begin
                    first_reg[didx] <= free_top_reg;
                end
                last_reg[didx] <= free_top_reg;
            end
            else if (cmd.exec && rel_ok && lvl_in)
            begin
                if (!p_in)
                begin
                    first_reg[lidx] <= n_in ? next_rd_reg : NIL;
                end
                if (!n_in)
                begin
                    last_reg[lidx] <= p_in ? prev_rd_reg : NIL;
                end
            end
        end
    end

    assign slot_index = slot_index_reg;
    assign node_level = node_level_reg;
    assign status     = status_reg;

endmodule
